// ===== src/lr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared types and constants for the Bresenham line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

    // Field widths of the request and pixel items
    localparam int COORD_W  = 9;
    localparam int OFFSET_W = 20;
    localparam int COLOR_W  = 32;

    // Four bytes per pixel, so the byte offset is the pixel index shifted by two
    localparam int BPP_SHIFT = 2;

    // Decision variable and increment widths
    localparam int ERR_W = 12;
    localparam int INC_W = 11;

    // Request kinds carried on tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Register index decoded from the APB address
    localparam logic REG_DRAW_COLOR = 1'b0;

    // One emitted pixel
    typedef struct packed {
        logic                last;
        logic [COLOR_W-1:0]  rgba;
        logic [OFFSET_W-1:0] offset;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  x;
    } t_pixel;

endpackage

// ===== src/lr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer core
// Holds the line state, sets it up on a load request and advances one pixel
// on every step request, giving the pixel as a result item.
// ----------------------------------------------------------------------------
module lr_core #(
    parameter int IMAGE_W = 512,
    parameter int IMAGE_H = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_op,
    input  logic [lr_pkg::COORD_W-1:0]  i_start_x,
    input  logic [lr_pkg::COORD_W-1:0]  i_start_y,
    input  logic [lr_pkg::COORD_W-1:0]  i_end_x,
    input  logic [lr_pkg::COORD_W-1:0]  i_end_y,
    input  logic [lr_pkg::COLOR_W-1:0]  i_color,
    output logic                        o_res_valid,
    output lr_pkg::t_pixel              o_res,
    output logic                        o_active
);
    import lr_pkg::*;

    localparam int LIM_W = 13;
    localparam int IDX_W = OFFSET_W - BPP_SHIFT;
    localparam logic [LIM_W-1:0] X_MAX = LIM_W'(IMAGE_W - 1);
    localparam logic [LIM_W-1:0] Y_MAX = LIM_W'(IMAGE_H - 1);

    // Line state
    logic                     r_active;
    logic [COORD_W-1:0]       r_cx;
    logic [COORD_W-1:0]       r_cy;
    logic [COORD_W-1:0]       r_major_end;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [INC_W-1:0]  r_inc_s;
    logic signed [INC_W-1:0]  r_inc_d;
    logic                     r_steep;
    logic                     r_up;

    logic                     n_active;
    logic [COORD_W-1:0]       n_cx;
    logic [COORD_W-1:0]       n_cy;
    logic [COORD_W-1:0]       n_major_end;
    logic signed [ERR_W-1:0]  n_err;
    logic signed [INC_W-1:0]  n_inc_s;
    logic signed [INC_W-1:0]  n_inc_d;
    logic                     n_steep;
    logic                     n_up;

    // Load set-up signals
    logic [COORD_W-1:0] ax, ay, bx, by;
    logic [COORD_W-1:0] x0, y0, x1, y1;
    logic [COORD_W-1:0] dx, ady, major, minor;
    logic               ld_up, ld_steep;

    // Step signals
    logic                    is_last;
    logic                    diag;
    logic [ERR_W-1:0]        inc_sel;
    logic [COORD_W-1:0]      y_minor;
    logic [IDX_W-1:0]        pix_idx;

    // Saturate the endpoints to the image and order them by column
    always_comb begin
        ax = ({4'b0, i_start_x} > X_MAX) ? X_MAX[COORD_W-1:0] : i_start_x;
        ay = ({4'b0, i_start_y} > Y_MAX) ? Y_MAX[COORD_W-1:0] : i_start_y;
        bx = ({4'b0, i_end_x} > X_MAX) ? X_MAX[COORD_W-1:0] : i_end_x;
        by = ({4'b0, i_end_y} > Y_MAX) ? Y_MAX[COORD_W-1:0] : i_end_y;
        if (ax > bx) begin
            x0 = bx; y0 = by; x1 = ax; y1 = ay;
        end else begin
            x0 = ax; y0 = ay; x1 = bx; y1 = by;
        end
        dx       = x1 - x0;
        ld_up    = y1 < y0;
        ady      = ld_up ? (y0 - y1) : (y1 - y0);
        ld_steep = ady > dx;
        major    = ld_steep ? ady : dx;
        minor    = ld_steep ? dx : ady;
    end

    // Current pixel and the Bresenham step from it
    always_comb begin
        is_last = (r_steep ? r_cy : r_cx) == r_major_end;
        diag    = r_err > 0;
        inc_sel = diag ? {r_inc_d[INC_W-1], r_inc_d} : {r_inc_s[INC_W-1], r_inc_s};
        y_minor = r_up ? (r_cy - 1'b1) : (r_cy + 1'b1);
        pix_idx = IDX_W'(r_cy) * IDX_W'(IMAGE_W) + IDX_W'(r_cx);

        o_res.x      = r_cx;
        o_res.y      = r_cy;
        o_res.offset = {pix_idx, {BPP_SHIFT{1'b0}}};
        o_res.rgba   = i_color;
        o_res.last   = is_last;
        o_res_valid  = i_accept && (i_op == OP_STEP) && r_active;
    end

    // Next state
    always_comb begin
        n_active    = r_active;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_major_end = r_major_end;
        n_err       = r_err;
        n_inc_s     = r_inc_s;
        n_inc_d     = r_inc_d;
        n_steep     = r_steep;
        n_up        = r_up;
        if (i_accept && (i_op == OP_LOAD)) begin
            n_active    = 1'b1;
            n_cx        = x0;
            n_cy        = y0;
            n_major_end = ld_steep ? y1 : x1;
            n_err       = $signed({2'b0, minor, 1'b0}) - $signed({3'b0, major});
            n_inc_s     = $signed({1'b0, minor, 1'b0});
            n_inc_d     = $signed({1'b0, minor, 1'b0}) - $signed({1'b0, major, 1'b0});
            n_steep     = ld_steep;
            n_up        = ld_up;
        end else if (o_res_valid) begin
            if (is_last) begin
                n_active = 1'b0;
            end else begin
                n_err = r_err + $signed(inc_sel);
                if (r_steep) begin
                    n_cy = y_minor;
                    if (diag) begin
                        n_cx = r_cx + 1'b1;
                    end
                end else begin
                    n_cx = r_cx + 1'b1;
                    if (diag) begin
                        n_cy = y_minor;
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_major_end <= '0;
            r_err       <= '0;
            r_inc_s     <= '0;
            r_inc_d     <= '0;
            r_steep     <= 1'b0;
            r_up        <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_major_end <= n_major_end;
            r_err       <= n_err;
            r_inc_s     <= n_inc_s;
            r_inc_d     <= n_inc_d;
            r_steep     <= n_steep;
            r_up        <= n_up;
        end
    end

    assign o_active = r_active;

endmodule

// ===== src/line_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer
// Bresenham line rasterizer for all octants with an APB colour register.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes requests. tuser = 0 loads a line from the two
//   endpoints in tdata; it produces no pixel. tuser = 1 asks for the next
//   pixel of the loaded line; with no line loaded it produces nothing.
//   Each pixel leaves on the master stream with its column, row, byte
//   offset into a row-major 4-byte-per-pixel framebuffer and the colour held
//   in the draw colour register (APB, address 0). tlast marks the final
//   pixel; a line of major length L gives L+1 pixels.
//   A step request is accepted every cycle while the skid register is empty.
//   Its pixel is registered in the output register; when the receiver
//   stalls, one further pixel is held in the skid register and s_tready
//   then falls until that entry moves into the output register. The per-step
//   path is one add and compare on the error term plus the row multiply for
//   the offset. Reset clears the line state, the colour register and the
//   output and skid valid flags; s_tready is high once reset is released.
//   The colour register must only be written while no pixel is pending.
// ----------------------------------------------------------------------------
module line_rasterizer #(
    parameter int IMAGE_W = 512,
    parameter int IMAGE_H = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // start_x[8:0], start_y[17:9], end_x[26:18], end_y[35:27]
    input  logic        s_tuser,   // op: 0 load, 1 step
    // Pixel stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // pixel_x[8:0], pixel_y[17:9], byte_offset[37:18], rgba[69:38]
    output logic        m_tlast,   // last pixel of the line
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lr_pkg::*;

    logic [COLOR_W-1:0] r_color;
    logic               in_accept;
    logic               out_take;
    logic               res_valid;
    t_pixel             res;
    logic               line_active;

    logic               r_out_valid;
    t_pixel             r_out;
    logic               r_skid_valid;
    t_pixel             r_skid;

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DRAW_COLOR) ? r_color : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_DRAW_COLOR)) begin
            r_color <= pwdata;
        end
    end

    // Request acceptance
    assign s_tready  = !r_skid_valid;
    assign in_accept = s_tvalid && s_tready;

    lr_core #(
        .IMAGE_W (IMAGE_W),
        .IMAGE_H (IMAGE_H)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_op        (s_tuser),
        .i_start_x   (s_tdata[8:0]),
        .i_start_y   (s_tdata[17:9]),
        .i_end_x     (s_tdata[26:18]),
        .i_end_y     (s_tdata[35:27]),
        .i_color     (r_color),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_active    (line_active)
    );

    // Output register with one skid entry
    assign out_take = r_out_valid && m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (res_valid) begin
                r_out <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00, r_out.rgba, r_out.offset, r_out.y, r_out.x};
    assign m_tlast  = r_out.last;

    // Assertions
    a_skid_needs_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_skid_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !m_tready))
        else $error("skid entry filled without an output stall");

    a_last_ends_line : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.last) |=> !line_active)
        else $error("line still active after its last pixel");

    a_step_idle_silent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (s_tuser == OP_STEP) && !line_active) |-> !res_valid)
        else $error("pixel produced with no line loaded");

endmodule

// ===== sim/line_rasterizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer testbench
// Drives load and step requests into the rasterizer with random gaps on
// both streams, predicts every pixel from its own copy of the Bresenham
// state and checks each pixel field by field, in order. The draw colour is
// written over APB between phases, read back, and run through its extremes.
// ----------------------------------------------------------------------------
module line_rasterizer_tb;
    import lr_pkg::*;

    localparam int IMG_W       = 512;
    localparam int IMG_H       = 512;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 4;
    localparam int PHASES      = 6;
    localparam int PHASE_QUOTA = 325;
    localparam logic [31:0] DIRECT_COLOR = 32'hFF00_00FF;
    localparam logic [2:0]  COLOR_ADDR   = 3'(4 * int'(REG_DRAW_COLOR));

    // One row of the directed table
    typedef struct {
        logic   op;
        logic [COORD_W-1:0] sx, sy, ex, ey;
        bit     typed;
        bit     want;
        t_pixel px;
    } t_stim;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predicted line state, mirrors the block after reset
    bit                 ln_active   = 1'b0;
    logic [COORD_W-1:0] ln_x        = '0;
    logic [COORD_W-1:0] ln_y        = '0;
    logic [COORD_W-1:0] ln_end      = '0;
    int                 ln_err      = 0;
    int                 ln_straight = 0;
    int                 ln_diag     = 0;
    bit                 ln_steep    = 1'b0;
    bit                 ln_up       = 1'b0;
    logic [31:0]        ln_color    = '0;

    t_pixel      pixels_due [$];
    t_stim       directed [$];
    int unsigned mismatches     = 0;
    int unsigned requests_taken = 0;
    int unsigned cycle_count    = 0;
    int unsigned tx_max_wait    = 10;
    int unsigned rx_max_wait    = 10;
    int unsigned rx_wait        = 0;
    t_pixel      rx_want;

    line_rasterizer #(
        .IMAGE_W (IMG_W),
        .IMAGE_H (IMG_H)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("check failed: %s got %h want %h", what, got, want);
    endtask

    // Bresenham line state: a load sets up the line, a step yields the next
    // pixel. Returns 1 when the request produces a pixel.
    function automatic bit advance_line(logic op, logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                                        logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
                                        output t_pixel px);
        int ax, ay, bx, by, dx, dy, t, major, minor;
        bit steep, up, diag;
        px = '0;
        if (op == OP_LOAD) begin
            // Endpoints saturate to the image, then are ordered by x
            ax = (sx > IMG_W - 1) ? IMG_W - 1 : sx;
            ay = (sy > IMG_H - 1) ? IMG_H - 1 : sy;
            bx = (ex > IMG_W - 1) ? IMG_W - 1 : ex;
            by = (ey > IMG_H - 1) ? IMG_H - 1 : ey;
            if (ax > bx) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            dx = bx - ax;
            dy = by - ay;
            up = dy < 0;
            if (up) begin
                dy = -dy;
            end
            steep       = dy > dx;
            major       = steep ? dy : dx;
            minor       = steep ? dx : dy;
            ln_err      = 2 * minor - major;
            ln_straight = 2 * minor;
            ln_diag     = 2 * (minor - major);
            ln_steep    = steep;
            ln_up       = up;
            ln_x        = COORD_W'(ax);
            ln_y        = COORD_W'(ay);
            ln_end      = COORD_W'(steep ? by : bx);
            ln_active   = 1'b1;
            return 1'b0;
        end
        if (!ln_active) begin
            return 1'b0;
        end
        px.x      = ln_x;
        px.y      = ln_y;
        px.offset = OFFSET_W'(4 * (int'(ln_x) + int'(ln_y) * IMG_W));
        px.rgba   = ln_color;
        px.last   = ((ln_steep ? ln_y : ln_x) == ln_end);
        if (px.last) begin
            ln_active = 1'b0;
        end else begin
            // A tie in the error term takes the straight step
            diag   = ln_err > 0;
            ln_err = ln_err + (diag ? ln_diag : ln_straight);
            if (ln_steep) begin
                ln_y = ln_up ? ln_y - 1'b1 : ln_y + 1'b1;
                if (diag) begin
                    ln_x = ln_x + 1'b1;
                end
            end else begin
                ln_x = ln_x + 1'b1;
                if (diag) begin
                    ln_y = ln_up ? ln_y - 1'b1 : ln_y + 1'b1;
                end
            end
        end
        return 1'b1;
    endfunction

    // Presents one request after a random gap and waits for it to be taken.
    // A typed row overrides the prediction with its own expectation.
    task automatic send_request(logic op, logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                                logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
                                bit typed, bit want, t_pixel typed_px);
        t_pixel      px;
        bit          got;
        int unsigned gap;
        gap = $urandom_range(0, tx_max_wait);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tdata  <= {4'b0, ey, ex, sy, sx};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        got = advance_line(op, sx, sy, ex, ey, px);
        if (typed) begin
            got = want;
            px  = typed_px;
        end
        if (got) begin
            pixels_due.push_back(px);
        end
        if (op == OP_LOAD || got) begin
            requests_taken++;
        end
    endtask

    // Waits until every pixel has come back and the block has settled.
    task automatic wait_idle();
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Writes the draw colour, then reads it back in a back-to-back transfer.
    task automatic write_colour(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COLOR_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        ln_color = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== value) begin
            report_mismatch("draw_color readback", prdata, value);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void add_row(logic op, int sx, int sy, int ex, int ey, bit typed,
                                    bit want, int x, int y, int off, bit last);
        t_stim row;
        row.op        = op;
        row.sx        = COORD_W'(sx);
        row.sy        = COORD_W'(sy);
        row.ex        = COORD_W'(ex);
        row.ey        = COORD_W'(ey);
        row.typed     = typed;
        row.want      = want;
        row.px.x      = COORD_W'(x);
        row.px.y      = COORD_W'(y);
        row.px.offset = OFFSET_W'(off);
        row.px.rgba   = DIRECT_COLOR;
        row.px.last   = last;
        directed.push_back(row);
    endfunction

    // Random lines, mostly short and stepped to the end, some abandoned,
    // some stepped past the end, with a share of random requests as noise.
    // Stepping stops once the phase quota is reached.
    task automatic run_lines(int unsigned quota);
        int unsigned start, cut, n;
        int          sx, sy, ex, ey;
        t_pixel      none;
        none  = '0;
        start = requests_taken;
        while (requests_taken - start < quota) begin
            tx_max_wait = ($urandom_range(0, 7) == 0) ? 0 : 10;
            if ($urandom_range(0, 9) == 0) begin
                send_request(1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)),
                             9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                             9'($urandom_range(0, 511)), 1'b0, 1'b0, none);
            end else begin
                sx = $urandom_range(0, 511);
                sy = $urandom_range(0, 511);
                if ($urandom_range(0, 15) == 0) begin
                    ex = $urandom_range(0, 511);
                    ey = $urandom_range(0, 511);
                end else begin
                    ex = sx + int'($urandom_range(0, 48)) - 24;
                    ey = sy + int'($urandom_range(0, 48)) - 24;
                    ex = (ex < 0) ? 0 : (ex > 511) ? 511 : ex;
                    ey = (ey < 0) ? 0 : (ey > 511) ? 511 : ey;
                end
                send_request(OP_LOAD, 9'(sx), 9'(sy), 9'(ex), 9'(ey), 1'b0, 1'b0, none);
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : 1000;
                n   = 0;
                while (ln_active && n < cut && (requests_taken - start < quota)) begin
                    send_request(OP_STEP, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                                 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                                 1'b0, 1'b0, none);
                    n++;
                end
                if ($urandom_range(0, 7) == 0) begin
                    send_request(OP_STEP, '0, '0, '0, '0, 1'b0, 1'b0, none);
                end
            end
        end
    endtask

    // Pixel side: random stalls per pixel, and the in-order comparison.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (pixels_due.size() == 0) begin
                    report_mismatch("pixel with none expected", m_tdata[31:0], '0);
                end else begin
                    rx_want = pixels_due.pop_front();
                    if (m_tdata[8:0] !== rx_want.x) begin
                        report_mismatch("pixel_x", m_tdata[8:0], rx_want.x);
                    end
                    if (m_tdata[17:9] !== rx_want.y) begin
                        report_mismatch("pixel_y", m_tdata[17:9], rx_want.y);
                    end
                    if (m_tdata[37:18] !== rx_want.offset) begin
                        report_mismatch("byte_offset", m_tdata[37:18], rx_want.offset);
                    end
                    if (m_tdata[69:38] !== rx_want.rgba) begin
                        report_mismatch("rgba", m_tdata[69:38], rx_want.rgba);
                    end
                    if (m_tlast !== rx_want.last) begin
                        report_mismatch("last", m_tlast, rx_want.last);
                    end
                end
                rx_wait = $urandom_range(0, rx_max_wait);
            end
            if (rx_wait != 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_pixel      none;
        logic [31:0] colours [PHASES];
        none       = '0;
        colours[0] = 32'hFFFF_FFFF;
        colours[1] = 32'h0000_0000;
        colours[2] = $urandom;
        colours[3] = 32'h8000_0001;
        colours[4] = $urandom;
        colours[5] = 32'hA5A5_5A5A;

        // Directed table: typed rows carry the expected pixel (or none)
        add_row(OP_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);           // step with no line
        add_row(OP_LOAD, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);           // single point at origin
        add_row(OP_STEP, 0, 0, 0, 0, 1, 1, 0, 0, 0, 1);
        add_row(OP_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);           // idle again after last
        add_row(OP_LOAD, 511, 511, 511, 511, 1, 0, 0, 0, 0, 0);   // single point at far corner
        add_row(OP_STEP, 0, 0, 0, 0, 1, 1, 511, 511, 20'hFFFFC, 1);
        add_row(OP_LOAD, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0);           // horizontal, endpoints swapped
        repeat (4) add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_LOAD, 5, 10, 5, 7, 0, 0, 0, 0, 0, 0);          // vertical going upward
        repeat (4) add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_LOAD, 0, 0, 2, 1, 0, 0, 0, 0, 0, 0);           // error term tie
        repeat (3) add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_LOAD, 0, 0, 511, 511, 0, 0, 0, 0, 0, 0);       // full diagonal
        add_row(OP_STEP, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0);
        add_row(OP_LOAD, 0, 511, 511, 0, 0, 0, 0, 0, 0, 0);       // load while active, rising
        add_row(OP_STEP, 0, 0, 0, 0, 1, 1, 0, 511, 20'hFF800, 0);
        add_row(OP_LOAD, 511, 0, 0, 511, 0, 0, 0, 0, 0, 0);       // swapped and rising
        add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_colour(DIRECT_COLOR);
        foreach (directed[i]) begin
            send_request(directed[i].op, directed[i].sx, directed[i].sy, directed[i].ex,
                         directed[i].ey, directed[i].typed, directed[i].want, directed[i].px);
        end
        s_tvalid <= 1'b0;
        wait_idle();

        // Random phases, each under its own colour; one runs with no stalls
        for (int p = 0; p < PHASES; p++) begin
            write_colour(colours[p]);
            rx_max_wait = (p == 2) ? 0 : 10;
            run_lines(PHASE_QUOTA);
            s_tvalid <= 1'b0;
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lr_pkg.sv
src/lr_core.sv
src/line_rasterizer.sv
sim/line_rasterizer_tb.sv
